/* rtl/fqkr_pkg.sv */
// fqkr_pkg: operation and status codes and the fixed port widths of the keyed fifo queue
// no dependencies; imported by fifo_queue_with_keyed_removal
package fqkr_pkg;

   localparam int OP_W   = 2;
   localparam int STAT_W = 2;
   localparam int PORT_W = 32;
   localparam int OCC_W  = 5;

   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_SERVE  = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

endpackage

/* rtl/fifo_queue_with_keyed_removal.sv */
// fifo_queue_with_keyed_removal: ordered queue of tag pairs held in a circular
// single-write, single-read memory, with serve, append, clear and remove-by-tags
// depends on fqkr_pkg
//
// usage: one transaction on the req_ channel carries an operation and two tags;
// each one gives exactly one transaction on the rsp_ channel (status, tags of the
// served or removed entry, occupancy afterwards), in order.
// append, clear and any operation on an empty queue go from idle straight to the
// finishing state, which registers the result and returns to idle for the next
// request. serve passes through the serve state for its one memory read.
// remove with n entries held and the match at position k (front is 0) scans
// entries 0 to k, then collapses the n - 1 - k entries behind it (one entry moved
// per cycle through the read and write ports); with no match all n are scanned.
// the single memory read port, one entry per cycle, sets the remove time.
// req_stall is high while a transaction is in progress. the result register
// lets a new request be accepted while the previous result is still stalled;
// its result then waits in the finishing state until rsp_stall drops.
// reset empties the queue and drops any pending result; the entry memory is not
// cleared, since only entries below the fill count are ever read.
module fifo_queue_with_keyed_removal #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TAG_WIDTH   = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fqkr_pkg::OP_W-1:0]     req_op,
   input  logic [fqkr_pkg::PORT_W-1:0]   req_given_tag,
   input  logic [fqkr_pkg::PORT_W-1:0]   req_family_tag,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fqkr_pkg::STAT_W-1:0]   rsp_status,
   output logic [fqkr_pkg::PORT_W-1:0]   rsp_out_given,
   output logic [fqkr_pkg::PORT_W-1:0]   rsp_out_family,
   output logic [fqkr_pkg::OCC_W-1:0]    rsp_occupancy
);
   import fqkr_pkg::*;

   localparam int StoreW = (TAG_WIDTH < PORT_W) ? TAG_WIDTH : PORT_W;
   localparam int AddrW  = $clog2(QUEUE_DEPTH);
   localparam int CntW   = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AddrW:0]   DepthA = (AddrW+1)'(QUEUE_DEPTH);
   localparam logic [CntW-1:0]  DepthC = CntW'(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      IDLE,
      SERVE,
      SCAN,
      SHIFT,
      FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [CntW-1:0]         count_ff, count_in;
   logic [AddrW-1:0]        head_ff, head_in;
   logic [AddrW-1:0]        idx_ff, idx_in;
   logic [StoreW-1:0]       key_given_ff, key_given_in;
   logic [StoreW-1:0]       key_family_ff, key_family_in;
   logic [STAT_W-1:0]       res_status_ff, res_status_in;
   logic [StoreW-1:0]       res_given_ff, res_given_in;
   logic [StoreW-1:0]       res_family_ff, res_family_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [StoreW-1:0]       rsp_given_ff, rsp_given_in;
   logic [StoreW-1:0]       rsp_family_ff, rsp_family_in;
   logic [OCC_W-1:0]        rsp_occ_ff, rsp_occ_in;

   logic [2*StoreW-1:0]     mem [QUEUE_DEPTH];
   logic [2*StoreW-1:0]     rd_data_ff;
   logic                    rd_en;
   logic [AddrW-1:0]        rd_addr;
   logic                    wr_en;
   logic [AddrW-1:0]        wr_addr;
   logic [2*StoreW-1:0]     wr_data;

   logic [StoreW-1:0]       rd_given;
   logic [StoreW-1:0]       rd_family;
   logic                    last_entry;
   logic                    last_move;
   logic                    key_match;

   function automatic logic [AddrW-1:0] wrap_addr(input logic [AddrW-1:0] base,
                                                  input logic [AddrW-1:0] off);
      logic [AddrW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DepthA) begin
         sum = sum - DepthA;
      end
      return sum[AddrW-1:0];
   endfunction

   assign rd_given   = rd_data_ff[2*StoreW-1:StoreW];
   assign rd_family  = rd_data_ff[StoreW-1:0];
   assign key_match  = (rd_given == key_given_ff) && (rd_family == key_family_ff);
   assign last_entry = (CntW'(idx_ff) + CntW'(1)) == count_ff;
   assign last_move  = (CntW'(idx_ff) + CntW'(2)) == count_ff;

   assign req_stall = (state_ff != IDLE);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      idx_in        = idx_ff;
      key_given_in  = key_given_ff;
      key_family_in = key_family_ff;
      res_status_in = res_status_ff;
      res_given_in  = res_given_ff;
      res_family_in = res_family_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_given_in  = rsp_given_ff;
      rsp_family_in = rsp_family_ff;
      rsp_occ_in    = rsp_occ_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               key_given_in  = req_given_tag[StoreW-1:0];
               key_family_in = req_family_tag[StoreW-1:0];
               res_status_in = ST_DONE;
               res_given_in  = '0;
               res_family_in = '0;
               idx_in        = '0;
               state_in      = FINISH;
               case (req_op)
                  OP_APPEND: begin
                     if (count_ff >= DepthC) begin
                        res_status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = wrap_addr(head_ff, AddrW'(count_ff));
                        wr_data  = {req_given_tag[StoreW-1:0], req_family_tag[StoreW-1:0]};
                        count_in = count_ff + CntW'(1);
                     end
                  end
                  OP_SERVE: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        state_in = SERVE;
                     end
                  end
                  OP_REMOVE: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        state_in = SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     count_in = '0;
                  end
               endcase
            end
         end
         SERVE: begin
            res_given_in  = rd_given;
            res_family_in = rd_family;
            head_in       = wrap_addr(head_ff, AddrW'(1));
            count_in      = count_ff - CntW'(1);
            state_in      = FINISH;
         end
         SCAN: begin
            // fetch the next entry ahead, used by both the scan and the collapse
            if (!last_entry) begin
               rd_en   = 1'b1;
               rd_addr = wrap_addr(head_ff, AddrW'(CntW'(idx_ff) + CntW'(1)));
            end
            if (key_match) begin
               res_given_in  = rd_given;
               res_family_in = rd_family;
               if (last_entry) begin
                  count_in = count_ff - CntW'(1);
                  state_in = FINISH;
               end else begin
                  state_in = SHIFT;
               end
            end else if (last_entry) begin
               res_status_in = ST_NOMATCH;
               state_in      = FINISH;
            end else begin
               idx_in = AddrW'(CntW'(idx_ff) + CntW'(1));
            end
         end
         SHIFT: begin
            // idx is the hole; the entry behind it is in the read register
            wr_en   = 1'b1;
            wr_addr = wrap_addr(head_ff, idx_ff);
            wr_data = rd_data_ff;
            if (last_move) begin
               count_in = count_ff - CntW'(1);
               state_in = FINISH;
            end else begin
               rd_en   = 1'b1;
               rd_addr = wrap_addr(head_ff, AddrW'(CntW'(idx_ff) + CntW'(2)));
               idx_in  = AddrW'(CntW'(idx_ff) + CntW'(1));
            end
         end
         FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_given_in  = res_given_ff;
               rsp_family_in = res_family_ff;
               rsp_occ_in    = OCC_W'(count_ff);
               state_in      = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      key_given_ff  <= key_given_in;
      key_family_ff <= key_family_in;
      res_status_ff <= res_status_in;
      res_given_ff  <= res_given_in;
      res_family_ff <= res_family_in;
      rsp_status_ff <= rsp_status_in;
      rsp_given_ff  <= rsp_given_in;
      rsp_family_ff <= rsp_family_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_given  = PORT_W'(rsp_given_ff);
   assign rsp_out_family = PORT_W'(rsp_family_ff);
   assign rsp_occupancy  = rsp_occ_ff;

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en && (rd_addr == wr_addr)))
      else $error("read and write of the same entry in one cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthC)
      else $error("fill count above queue depth");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == FINISH))
      else $error("result raised outside the finishing state");

   a_full_occupancy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_FULL)) |-> (rsp_occ_ff == OCC_W'(QUEUE_DEPTH)))
      else $error("full status without a full queue");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_op == OP_CLEAR)) |=> (count_ff == '0))
      else $error("clear left entries in the queue");

endmodule

/* tb/fqkr_checker.sv */
// fqkr_checker: watches both channels of the keyed fifo queue, keeps its own copy of the
// queue, predicts one result per request transaction and compares each result transaction
// depends on fqkr_pkg; instantiated beside the block by tb_fifo_queue_with_keyed_removal
module fqkr_checker #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TAG_WIDTH   = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [fqkr_pkg::OP_W-1:0]     req_op,
   input  logic [fqkr_pkg::PORT_W-1:0]   req_given_tag,
   input  logic [fqkr_pkg::PORT_W-1:0]   req_family_tag,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [fqkr_pkg::STAT_W-1:0]   rsp_status,
   input  logic [fqkr_pkg::PORT_W-1:0]   rsp_out_given,
   input  logic [fqkr_pkg::PORT_W-1:0]   rsp_out_family,
   input  logic [fqkr_pkg::OCC_W-1:0]    rsp_occupancy,
   output int                            fail_count,
   output int                            results_owed
);

   import fqkr_pkg::*;

   localparam logic [PORT_W-1:0] TAG_MASK =
      (TAG_WIDTH >= PORT_W) ? {PORT_W{1'b1}} : ((PORT_W'(1) << TAG_WIDTH) - 1);

   typedef struct packed {
      logic [PORT_W-1:0] given;
      logic [PORT_W-1:0] family;
   } tag_pair_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [PORT_W-1:0] given;
      logic [PORT_W-1:0] family;
      logic [OCC_W-1:0]  occupancy;
   } queue_result_type;

   tag_pair_type     held_entries[QUEUE_DEPTH];
   int               held_count;
   queue_result_type owed_results[$];

   function automatic queue_result_type apply_queue_op(input logic [OP_W-1:0] op,
                                                       input logic [PORT_W-1:0] given_in,
                                                       input logic [PORT_W-1:0] family_in);
      queue_result_type res;
      tag_pair_type     key;
      int               hit;
      res        = '0;
      res.status = ST_DONE;
      key.given  = given_in & TAG_MASK;
      key.family = family_in & TAG_MASK;
      hit        = -1;
      case (op)
         OP_APPEND: begin
            if (held_count >= QUEUE_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               held_entries[held_count] = key;
               held_count++;
            end
         end
         OP_SERVE, OP_REMOVE: begin
            if (held_count == 0) begin
               res.status = ST_EMPTY;
            end else if (op == OP_SERVE) begin
               hit = 0;
            end else begin
               res.status = ST_NOMATCH;
               for (int i = 0; i < held_count; i++)
                  if (hit < 0 && held_entries[i] == key) hit = i;
            end
            if (hit >= 0) begin
               res.status = ST_DONE;
               res.given  = held_entries[hit].given;
               res.family = held_entries[hit].family;
               // entries behind the removed one close up toward the front
               for (int i = hit; i + 1 < held_count; i++)
                  held_entries[i] = held_entries[i + 1];
               held_count--;
            end
         end
         default: held_count = 0;
      endcase
      res.occupancy = OCC_W'(held_count);
      return res;
   endfunction

   task automatic check_field(input string what, input logic [PORT_W-1:0] want,
                              input logic [PORT_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         held_count = 0;
         owed_results.delete();
      end else begin
         if (req_valid && !req_stall)
            owed_results.push_back(apply_queue_op(req_op, req_given_tag, req_family_tag));
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               $display("%0t: unexpected result transaction, expected none, actual %h %h %h %h",
                        $time, rsp_status, rsp_out_given, rsp_out_family, rsp_occupancy);
               fail_count++;
            end else begin
               want = owed_results.pop_front();
               check_field("status", PORT_W'(want.status), PORT_W'(rsp_status));
               check_field("out_given", want.given, rsp_out_given);
               check_field("out_family", want.family, rsp_out_family);
               check_field("occupancy", PORT_W'(want.occupancy), PORT_W'(rsp_occupancy));
            end
         end
      end
      results_owed <= owed_results.size();
   end

endmodule

/* tb/tb_fifo_queue_with_keyed_removal.sv */
// tb_fifo_queue_with_keyed_removal: clock, reset and request stimulus for the keyed fifo
// queue, random stall on the result side, watchdog and final verdict
// depends on fqkr_pkg, fifo_queue_with_keyed_removal and fqkr_checker
module tb_fifo_queue_with_keyed_removal;

   import fqkr_pkg::*;

   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int END_DRAIN_CYCLES = 24;
   localparam int PHASE_ITEMS      = 425;
   localparam int POOL_SIZE        = 6;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid      = 1'b0;
   logic              req_stall;
   logic [OP_W-1:0]   req_op         = OP_CLEAR;
   logic [PORT_W-1:0] req_given_tag  = '0;
   logic [PORT_W-1:0] req_family_tag = '0;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [PORT_W-1:0] rsp_out_given;
   logic [PORT_W-1:0] rsp_out_family;
   logic [OCC_W-1:0]  rsp_occupancy;

   int fail_count;
   int results_owed;
   int idle_cycles    = 0;
   int send_idle_pct  = 17;
   int recv_idle_pct  = 66;

   logic [PORT_W-1:0] pool_given[POOL_SIZE];
   logic [PORT_W-1:0] pool_family[POOL_SIZE];

   fifo_queue_with_keyed_removal #(
      .QUEUE_DEPTH (16),
      .TAG_WIDTH   (32)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_given_tag  (req_given_tag),
      .req_family_tag (req_family_tag),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_given  (rsp_out_given),
      .rsp_out_family (rsp_out_family),
      .rsp_occupancy  (rsp_occupancy)
   );

   fqkr_checker #(
      .QUEUE_DEPTH (16),
      .TAG_WIDTH   (32)
   ) result_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_given_tag  (req_given_tag),
      .req_family_tag (req_family_tag),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_given  (rsp_out_given),
      .rsp_out_family (rsp_out_family),
      .rsp_occupancy  (rsp_occupancy),
      .fail_count     (fail_count),
      .results_owed   (results_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // returns at the edge that accepted the transaction
   task automatic push_request(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] given,
                               input logic [PORT_W-1:0] family);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_given_tag  <= given;
      req_family_tag <= family;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic run_random(input int count);
      bit                filling;
      int                pick;
      int                slot;
      logic [OP_W-1:0]   op;
      logic [PORT_W-1:0] given;
      logic [PORT_W-1:0] family;
      filling = 1'b1;
      repeat (count) begin
         if ($urandom_range(29) == 0) filling = !filling;
         pick = $urandom_range(99);
         if (pick < 2)                          op = OP_CLEAR;
         else if (pick < (filling ? 70 : 28))   op = OP_APPEND;
         else if (pick < (filling ? 84 : 62))   op = OP_SERVE;
         else                                   op = OP_REMOVE;
         slot   = $urandom_range(POOL_SIZE - 1);
         given  = pool_given[slot];
         family = pool_family[slot];
         pick   = $urandom_range(99);
         if (pick < 15) begin
            given  = $urandom();
            family = $urandom();
         end else if (pick < 28 && op == OP_REMOVE) begin
            family = pool_family[$urandom_range(POOL_SIZE - 1)];
         end
         push_request(op, given, family);
      end
   endtask

   initial begin
      logic [PORT_W-1:0] twin_given;
      logic [PORT_W-1:0] twin_family;
      logic [PORT_W-1:0] back_given;
      logic [PORT_W-1:0] back_family;
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_given[i]  = $urandom();
         pool_family[i] = $urandom();
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty queue cases
      push_request(OP_SERVE, '0, '0);
      push_request(OP_REMOVE, '1, '1);
      push_request(OP_CLEAR, '0, '0);
      // fill to the top, with one pair held twice
      push_request(OP_APPEND, '0, '0);
      push_request(OP_APPEND, '1, '1);
      push_request(OP_APPEND, 32'hAAAA_AAAA, 32'h5555_5555);
      push_request(OP_APPEND, 32'h5555_5555, 32'hAAAA_AAAA);
      twin_given  = $urandom();
      twin_family = $urandom();
      push_request(OP_APPEND, twin_given, twin_family);
      repeat (2) push_request(OP_APPEND, $urandom(), $urandom());
      push_request(OP_APPEND, twin_given, twin_family);
      back_given  = '0;
      back_family = '0;
      repeat (8) begin
         back_given  = $urandom();
         back_family = $urandom();
         push_request(OP_APPEND, back_given, back_family);
      end
      push_request(OP_APPEND, 32'h1234_5678, 32'h9ABC_DEF0);
      // only one of the two tags matches
      push_request(OP_REMOVE, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
      push_request(OP_REMOVE, twin_given, twin_family);
      push_request(OP_REMOVE, back_given, back_family);
      push_request(OP_SERVE, '0, '0);
      push_request(OP_CLEAR, '0, '0);

      run_random(PHASE_ITEMS);
      send_idle_pct = 66;
      recv_idle_pct <= 17;
      run_random(PHASE_ITEMS);
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      run_random(PHASE_ITEMS);
      req_valid <= 1'b0;

      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (END_DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
